// ----- rtl/prf_pkg.sv -----
// Shared types and constants for the pattern removal stream filter.
`default_nettype none
package prf_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = BYTE_W * PATTERN_MAX;
  localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int REM_W       = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_FIELD_W = 4;

  // item queue between front and back (power of two depth)
  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

  // result queue at the output (power of two depth)
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN     = 2'd1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } item_t;

  typedef struct packed {
    byte_t             data;
    logic              valid;
    logic              last;
    logic [REM_W-1:0]  count;
  } result_t;

  // configuration seen by the back end; len already clamped to PATTERN_MAX
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [CNT_W-1:0] len;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOOP,
    ST_END
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/prf_front.sv -----
// Front end: configuration registers and input acceptance into the item queue.
`default_nettype none
module prf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [prf_pkg::BYTE_W-1:0]          in_byte,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [prf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output prf_pkg::item_t                      q_item,
  output prf_pkg::cfg_t                       cfg
);

  logic [prf_pkg::PAT_W-1:0]       pattern_r;
  logic [prf_pkg::LEN_FIELD_W-1:0] len_r;
  logic [prf_pkg::PAT_W-1:0]       pattern_nxt;
  logic [prf_pkg::LEN_FIELD_W-1:0] len_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    pattern_nxt = pattern_r;
    len_nxt     = len_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        prf_pkg::CFG_IDX_PATTERN: pattern_nxt = cfg_data[prf_pkg::PAT_W-1:0];
        prf_pkg::CFG_IDX_LEN:     len_nxt     = cfg_data[prf_pkg::LEN_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= '0;
    end else begin
      pattern_r <= pattern_nxt;
      len_r     <= len_nxt;
    end
  end

  // lengths beyond the window size act as the full window
  always_comb begin
    cfg.pattern = pattern_r;
    if ({{prf_pkg::CNT_W{1'b0}}, len_r} > (prf_pkg::CNT_W + prf_pkg::LEN_FIELD_W)'(prf_pkg::PATTERN_MAX))
      cfg.len = prf_pkg::CNT_W'(prf_pkg::PATTERN_MAX);
    else
      cfg.len = prf_pkg::CNT_W'(len_r);
  end

  assign in_full     = q_full;
  assign q_push      = in_push && !q_full;
  assign q_item.data = in_byte;
  assign q_item.last = in_last;

endmodule
`default_nettype wire

// ----- rtl/prf_itemq.sv -----
// Short item queue that decouples the front end from the back end.
`default_nettype none
module prf_itemq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prf_pkg::item_t item_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output prf_pkg::item_t item_out
);

  prf_pkg::item_t                  mem_r [prf_pkg::IQ_DEPTH];
  logic [prf_pkg::IQ_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [prf_pkg::IQ_CNT_W-1:0]    count_r, count_nxt;
  logic                            push_ok, pop_ok;

  assign full     = (count_r == prf_pkg::IQ_CNT_W'(prf_pkg::IQ_DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign item_out = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok)
      count_nxt = count_r + prf_pkg::IQ_CNT_W'(1);
    else if (pop_ok && !push_ok)
      count_nxt = count_r - prf_pkg::IQ_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) wr_ptr_r <= wr_ptr_r + prf_pkg::IQ_PTR_W'(1);
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + prf_pkg::IQ_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= item_in;
  end

endmodule
`default_nettype wire

// ----- rtl/prf_back.sv -----
// Back end: window, pattern match, emit/drop sequencer and end-of-text flush.
`default_nettype none
module prf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  prf_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  prf_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic             oq_full,
  output logic             oq_push,
  output prf_pkg::result_t oq_data
);

  localparam int PM = prf_pkg::PATTERN_MAX;

  prf_pkg::state_t              state_r, state_nxt;
  prf_pkg::byte_t               w_r   [PM];
  prf_pkg::byte_t               wv    [PM];
  prf_pkg::byte_t               w_nxt [PM];
  logic [prf_pkg::CNT_W-1:0]    cnt_r, cv, cnt_nxt, shamt;
  logic                         last_r, lv;
  logic                         pend_v_r;
  prf_pkg::byte_t               pend_b_r;
  logic [prf_pkg::REM_W-1:0]    rem_r, rem_nxt;

  logic go, step;
  logic loop_c, flush_c, match_c, emit_c, more, fin, pend_load;

  // go: this cycle's action can proceed (room downstream, item if needed)
  always_comb begin
    go = 1'b0;
    unique case (state_r)
      prf_pkg::ST_RUN:  go = !oq_full && q_valid;
      prf_pkg::ST_LOOP: go = !oq_full;
      prf_pkg::ST_END:  go = !oq_full;
      default:          go = 1'b0;
    endcase
  end

  assign step  = go && (state_r != prf_pkg::ST_END);
  assign q_pop = go && (state_r == prf_pkg::ST_RUN);

  // one iteration of the window sequencer
  always_comb begin
    logic                    match_all;
    logic [prf_pkg::CNT_W:0] src;
    lv = (state_r == prf_pkg::ST_RUN) ? q_item.last : last_r;
    cv = (state_r == prf_pkg::ST_RUN) ? cnt_r + prf_pkg::CNT_W'(1) : cnt_r;
    for (int i = 0; i < PM; i++) begin
      if (state_r == prf_pkg::ST_RUN && prf_pkg::CNT_W'(i) == cnt_r)
        wv[i] = q_item.data;
      else
        wv[i] = w_r[i];
    end

    match_all = 1'b1;
    for (int i = 0; i < PM; i++) begin
      if (prf_pkg::CNT_W'(i) < cfg.len &&
          wv[i] != cfg.pattern[prf_pkg::BYTE_W*i +: prf_pkg::BYTE_W])
        match_all = 1'b0;
    end

    loop_c  = (cv != '0) && (cv >= cfg.len);
    flush_c = !loop_c && lv && (cv != '0);
    match_c = loop_c && (cfg.len != '0) && match_all;
    emit_c  = (loop_c && !match_c) || flush_c;

    if (match_c)     shamt = cfg.len;
    else if (emit_c) shamt = prf_pkg::CNT_W'(1);
    else             shamt = '0;

    cnt_nxt = cv - shamt;
    for (int i = 0; i < PM; i++) begin
      src = (prf_pkg::CNT_W + 1)'(i) + {1'b0, shamt};
      if (src < (prf_pkg::CNT_W + 1)'(PM))
        w_nxt[i] = wv[src[prf_pkg::IDX_W-1:0]];
      else
        w_nxt[i] = '0;
    end

    rem_nxt = (match_c && rem_r != '1) ? rem_r + prf_pkg::REM_W'(1) : rem_r;
    more    = ((cnt_nxt != '0) && (cnt_nxt >= cfg.len)) || (lv && cnt_nxt != '0);

    // in a closing step the newest emitted byte is held back until we know
    // whether it is the final result of the text
    pend_load = step && lv && emit_c && (pend_v_r || more);
    fin       = step && lv && !more && !(emit_c && pend_v_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prf_pkg::ST_RUN, prf_pkg::ST_LOOP: begin
        if (go) begin
          if (more)                        state_nxt = prf_pkg::ST_LOOP;
          else if (lv && emit_c && pend_v_r) state_nxt = prf_pkg::ST_END;
          else                             state_nxt = prf_pkg::ST_RUN;
        end
      end
      prf_pkg::ST_END: begin
        if (go) state_nxt = prf_pkg::ST_RUN;
      end
      default: state_nxt = prf_pkg::ST_RUN;
    endcase
  end

  // result write
  always_comb begin
    oq_push = 1'b0;
    oq_data = '0;
    unique case (state_r)
      prf_pkg::ST_END: begin
        oq_push       = go;
        oq_data.data  = pend_b_r;
        oq_data.valid = 1'b1;
        oq_data.last  = 1'b1;
        oq_data.count = rem_r;
      end
      prf_pkg::ST_RUN, prf_pkg::ST_LOOP: begin
        if (go) begin
          if (!lv) begin
            oq_push       = emit_c;
            oq_data.data  = wv[0];
            oq_data.valid = 1'b1;
          end else if (emit_c) begin
            if (pend_v_r) begin
              oq_push       = 1'b1;
              oq_data.data  = pend_b_r;
              oq_data.valid = 1'b1;
            end else if (!more) begin
              oq_push       = 1'b1;
              oq_data.data  = wv[0];
              oq_data.valid = 1'b1;
              oq_data.last  = 1'b1;
              oq_data.count = rem_nxt;
            end
          end else if (!more) begin
            oq_push       = 1'b1;
            oq_data.data  = pend_v_r ? pend_b_r : '0;
            oq_data.valid = pend_v_r;
            oq_data.last  = 1'b1;
            oq_data.count = rem_nxt;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= prf_pkg::ST_RUN;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      pend_v_r <= 1'b0;
      rem_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (step) begin
        cnt_r  <= cnt_nxt;
        last_r <= lv;
        rem_r  <= fin ? '0 : rem_nxt;
        if (pend_load)
          pend_v_r <= 1'b1;
        else if (fin)
          pend_v_r <= 1'b0;
      end else if (go) begin
        pend_v_r <= 1'b0;
        rem_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      w_r <= w_nxt;
      if (pend_load) pend_b_r <= wv[0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/prf_outq.sv -----
// Result queue that holds finished results until the receiver pops them.
`default_nettype none
module prf_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prf_pkg::result_t data_in,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output prf_pkg::result_t data_out
);

  prf_pkg::result_t             mem_r [prf_pkg::OQ_DEPTH];
  logic [prf_pkg::OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [prf_pkg::OQ_CNT_W-1:0] count_r, count_nxt;
  logic                         push_ok, pop_ok;

  assign full     = (count_r == prf_pkg::OQ_CNT_W'(prf_pkg::OQ_DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign data_out = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok)
      count_nxt = count_r + prf_pkg::OQ_CNT_W'(1);
    else if (pop_ok && !push_ok)
      count_nxt = count_r - prf_pkg::OQ_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) wr_ptr_r <= wr_ptr_r + prf_pkg::OQ_PTR_W'(1);
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + prf_pkg::OQ_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= data_in;
  end

endmodule
`default_nettype wire

// ----- rtl/pattern_removal_stream_filter.sv -----
// Top level of the pattern removal stream filter.
// Usage:
//  - Input channel (in_push/in_full): one text character per transaction,
//    in_last marks the final character of a text.
//  - Result channel (out_empty/out_pop): the oldest result sits on out_* while
//    out_empty is low; out_valid is low only on an empty closing result.
//    out_removed_count carries the removal count on the out_last result.
//  - Config channel (cfg_valid/cfg_ready, always ready): index 0 writes the
//    pattern bytes, index 1 the pattern length. Write only while idle.
//  - Accepted characters pass the item queue, their results the result queue.
//  - Throughput: 1 character per cycle in steady state while the result queue
//    has room. The back-end sequencer handles one emit/drop or flush step per
//    cycle, so a closing character takes one step per emit/drop or flush, plus
//    an ST_END step when its final result is a held-back byte, and a length
//    change can add steps on the next character.
//  - Reset (rst_n low, synchronous) empties both queues and the window and
//    clears the configuration to length 0 (pass-through).
//  - When the receiver stalls, the result queue fills, the sequencer holds,
//    the 4-entry item queue absorbs input and then in_full rises.
`default_nettype none
module pattern_removal_stream_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [prf_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               in_last,
  // result channel
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic [prf_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_valid,
  output logic                               out_last,
  output logic [prf_pkg::REM_W-1:0]          out_removed_count,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  prf_pkg::cfg_t    cfg;
  prf_pkg::item_t   iq_in, iq_out;
  prf_pkg::result_t oq_in, oq_out;
  logic             iq_push, iq_full, iq_pop, iq_empty;
  logic             oq_push, oq_full;

  // front: config registers, accept transaction into the item queue
  prf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (iq_full),
    .q_push    (iq_push),
    .q_item    (iq_in),
    .cfg       (cfg)
  );

  // decoupling queue between front and back
  prf_itemq u_itemq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (iq_push),
    .item_in  (iq_in),
    .full     (iq_full),
    .pop      (iq_pop),
    .empty    (iq_empty),
    .item_out (iq_out)
  );

  // back: window, match, emit/drop and flush sequencing
  prf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (!iq_empty),
    .q_item  (iq_out),
    .q_pop   (iq_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_in)
  );

  // result queue parts the sequencer from the receiver
  prf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .data_in  (oq_in),
    .full     (oq_full),
    .pop      (out_pop),
    .empty    (out_empty),
    .data_out (oq_out)
  );

  assign out_byte          = oq_out.data;
  assign out_valid         = oq_out.valid;
  assign out_last          = oq_out.last;
  assign out_removed_count = oq_out.count;

endmodule
`default_nettype wire

// ----- rtl/prf_checker.sv -----
// Port-level checker for the pattern removal stream filter, with its bind.
`default_nettype none
module prf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_push,
  input logic                           in_full,
  input logic [prf_pkg::BYTE_W-1:0]     in_byte,
  input logic                           in_last,
  input logic                           out_pop,
  input logic                           out_empty,
  input logic [prf_pkg::BYTE_W-1:0]     out_byte,
  input logic                           out_valid,
  input logic                           out_last,
  input logic [prf_pkg::REM_W-1:0]      out_removed_count,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [prf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [prf_pkg::CFG_DATA_W-1:0] cfg_data
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte) && $stable(out_valid)
      && $stable(out_last) && $stable(out_removed_count))
    else $error("result changed while stalled");

  // an empty result only closes a text
  a_empty_is_closing: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_valid |-> out_last && out_byte == '0)
    else $error("empty result that is not a closing result");

  // removal count only on the closing result
  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_last |-> out_removed_count == '0)
    else $error("removal count on a non-closing result");

endmodule

bind pattern_removal_stream_filter prf_checker u_prf_checker (.*);
`default_nettype wire

// ----- tb/tb_pattern_removal_stream_filter.sv -----
// Self-checking testbench for the pattern removal stream filter: queued stimulus, shadow predictor.
`timescale 1ns / 100ps

module tb_pattern_removal_stream_filter;

  localparam int CLK_HALF     = 4;        // 8 ns period
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_CHARS = 480;
  localparam int SETTLE       = 32;       // 8-byte flush, both queues
  localparam int CYCLE_LIMIT  = 200000;   // ~500 characters, each with a full flush and the longest stalls
  localparam int MAX_GAP      = 5;
  localparam int MAX_REPORTS  = 40;
  localparam int REM_MAX      = (1 << prf_pkg::REM_W) - 1;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_push   = 1'b0;
  logic                             in_full;
  logic [prf_pkg::BYTE_W-1:0]       in_byte   = '0;
  logic                             in_last   = 1'b0;
  logic                             out_pop   = 1'b0;
  logic                             out_empty;
  logic [prf_pkg::BYTE_W-1:0]       out_byte;
  logic                             out_valid;
  logic                             out_last;
  logic [prf_pkg::REM_W-1:0]        out_removed_count;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [prf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [prf_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

  pattern_removal_stream_filter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_byte          (out_byte),
    .out_valid         (out_valid),
    .out_last          (out_last),
    .out_removed_count (out_removed_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the filter: configuration as last written, the window of held
  // characters and the removal count of the open text.
  // ---------------------------------------------------------------------------
  logic [prf_pkg::PAT_W-1:0]       pat_shadow   = '0;
  logic [prf_pkg::LEN_FIELD_W-1:0] len_shadow   = '0;
  prf_pkg::byte_t                  held_chars [prf_pkg::PATTERN_MAX];
  int                              held_n       = 0;
  int                              removals_run = 0;

  prf_pkg::result_t  expected_q [$];   // filtered characters still owed by the block
  prf_pkg::item_t    text_backlog [$]; // characters waiting for the driver

  // bookkeeping
  int               chars_queued   = 0;
  int               chars_taken    = 0;
  int               rand_chars     = 0;
  int               results_seen   = 0;
  int               texts_closed   = 0;
  int               removals_total = 0;
  int               reg_writes     = 0;
  int               mismatches     = 0;
  int               cycle_count    = 0;
  int               in_wait        = 0;
  int               out_wait       = 0;
  bit               in_calm        = 1'b0;   // no gaps on the input side
  bit               out_calm       = 1'b0;   // no stalls on the result side
  prf_pkg::byte_t   alpha_base     = '0;     // small alphabet so random texts hit the pattern
  prf_pkg::item_t   next_char;
  prf_pkg::result_t want;

  initial begin
    foreach (held_chars[i]) held_chars[i] = '0;
  end

  // Lengths above the window size behave as the full window.
  function automatic int active_len();
    int n;
    n = int'(len_shadow);
    if (n > prf_pkg::PATTERN_MAX) n = prf_pkg::PATTERN_MAX;
    if (n > 8) n = 8;
    return n;
  endfunction

  function automatic void drop_held(int n);
    for (int i = 0; i + n < held_n; i++) held_chars[i] = held_chars[i + n];
    held_n -= n;
  endfunction

  // One accepted character: match or emit from the front of the window until
  // fewer than the pattern length remain, then flush on the closing character.
  function automatic void filter_char(prf_pkg::byte_t ch, logic is_last);
    prf_pkg::result_t batch [$];
    int               n;
    int               made;
    bit               hit;
    n    = active_len();
    made = 0;
    if (held_n >= prf_pkg::PATTERN_MAX) held_n = prf_pkg::PATTERN_MAX - 1;
    held_chars[held_n] = ch;
    held_n++;
    while (held_n > 0 && held_n >= n) begin
      hit = (n > 0);
      for (int i = 0; i < n; i++)
        if (held_chars[i] != pat_shadow[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        drop_held(n);
        if (removals_run < REM_MAX) removals_run++;
        removals_total++;
      end else begin
        batch.push_back('{data: held_chars[0], valid: 1'b1, last: 1'b0, count: '0});
        made++;
        drop_held(1);
      end
    end
    if (is_last) begin
      for (int i = 0; i < held_n; i++) begin
        batch.push_back('{data: held_chars[i], valid: 1'b1, last: 1'b0, count: '0});
        made++;
      end
      held_n = 0;
      // nothing left to emit: the text still closes with an empty result
      if (made == 0) begin
        batch.push_back('{data: '0, valid: 1'b0, last: 1'b0, count: '0});
        made++;
      end
      batch[made-1].last  = 1'b1;
      batch[made-1].count = prf_pkg::REM_W'(removals_run);
      removals_run = 0;
      foreach (held_chars[i]) held_chars[i] = '0;
    end
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endfunction

  task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
               $time, results_seen, what, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents the backlog one character per transaction, with a
  // random gap drawn after every accepted character. An item stays on the
  // port while in_full holds it off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_byte <= '0;
      in_last <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        filter_char(in_byte, in_last);
        chars_taken++;
        in_wait = in_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!in_push || !in_full) begin
        if (in_wait > 0) begin
          in_wait--;
          in_push <= 1'b0;
        end else if (text_backlog.size() > 0) begin
          next_char = text_backlog.pop_front();
          in_push <= 1'b1;
          in_byte <= next_char.data;
          in_last <= next_char.last;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every popped result is checked against the oldest
  // expectation; a random stall is drawn after each one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (out_last) texts_closed++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, out_byte", 0, out_byte);
        end else begin
          want = expected_q.pop_front();
          if (out_byte != want.data)  report_mismatch("out_byte", want.data, out_byte);
          if (out_valid != want.valid) report_mismatch("out_valid", want.valid, out_valid);
          if (out_last != want.last)  report_mismatch("out_last", want.last, out_last);
          if (out_removed_count != want.count)
            report_mismatch("out_removed_count", want.count, out_removed_count);
        end
        out_wait = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, expected_q.size());
      $display("pattern_removal_stream_filter verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_char(prf_pkg::byte_t b, logic is_last);
    text_backlog.push_back('{data: b, last: is_last});
    chars_queued++;
  endfunction

  // first n bytes of w, low byte first; close marks the final one
  function automatic void queue_word(logic [63:0] w, int n, bit close);
    for (int i = 0; i < n; i++) push_char(w[8*i +: 8], close && (i == n - 1));
  endfunction

  // Register write; called at a rising edge, returns at one.
  task automatic write_reg(logic [prf_pkg::CFG_IDX_W-1:0] idx,
                           logic [prf_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == prf_pkg::CFG_IDX_PATTERN) pat_shadow = value;
    else if (idx == prf_pkg::CFG_IDX_LEN) len_shadow = value[prf_pkg::LEN_FIELD_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Every character taken, every result popped, then let the sequencer settle.
  task automatic wait_idle();
    while (chars_taken != chars_queued || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random text built from whole occurrences, partial occurrences, alphabet
  // characters and fully random bytes.
  task automatic queue_random_text(bit close);
    prf_pkg::byte_t chars [$];
    int             n;
    int             cut;
    n = active_len();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          if (n == 0) chars.push_back(prf_pkg::byte_t'($urandom));
          for (int i = 0; i < n; i++) chars.push_back(pat_shadow[8*i +: 8]);
        end
        3: begin
          cut = $urandom_range(1, (n > 1) ? n - 1 : 1);
          for (int i = 0; i < cut; i++) chars.push_back(pat_shadow[8*i +: 8]);
        end
        4, 5, 6: chars.push_back(alpha_base + prf_pkg::byte_t'($urandom_range(0, 2)));
        default: chars.push_back(prf_pkg::byte_t'($urandom));
      endcase
    end
    foreach (chars[i]) push_char(chars[i], close && (i == chars.size() - 1));
    rand_chars += chars.size();
  endtask

  // New pattern and/or length, with extremes and oversized lengths mixed in;
  // junk above the length field checks that only its low bits count.
  task automatic new_random_setting();
    logic [prf_pkg::CFG_DATA_W-1:0] pat;
    logic [prf_pkg::CFG_DATA_W-1:0] len_word;
    int                             which;
    alpha_base = prf_pkg::byte_t'($urandom);
    pat = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < prf_pkg::PATTERN_MAX; i++)
        pat[8*i +: 8] = alpha_base + prf_pkg::byte_t'($urandom_range(0, 2));
    len_word = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: len_word[prf_pkg::LEN_FIELD_W-1:0] = 4'd0;
      1: len_word[prf_pkg::LEN_FIELD_W-1:0] = 4'd8;
      2: len_word[prf_pkg::LEN_FIELD_W-1:0] = 4'($urandom_range(9, 15));
      default: len_word[prf_pkg::LEN_FIELD_W-1:0] = 4'($urandom_range(1, 8));
    endcase
    which = $urandom_range(0, 3);
    if (which != 1) write_reg(prf_pkg::CFG_IDX_PATTERN, pat);
    if (which != 2) write_reg(prf_pkg::CFG_IDX_LEN, len_word);
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting is length 0: plain pass-through
    queue_word(64'h00FF, 2, 1'b1);
    queue_word(64'h80, 1, 1'b1);
    wait_idle();

    // pattern of two zero bytes; zero is an ordinary character
    write_reg(prf_pkg::CFG_IDX_PATTERN, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(prf_pkg::CFG_IDX_LEN, 64'd2);
    queue_word(64'h0, 5, 1'b1);
    wait_idle();

    // "abc": back-to-back hits end in an empty closing result, then "aabc"
    // and an open "xab"
    write_reg(prf_pkg::CFG_IDX_PATTERN, 64'hDEAD_BEEF_0063_6261);
    write_reg(prf_pkg::CFG_IDX_LEN, 64'd3);
    queue_word(64'h63_62_61_63_62_61, 6, 1'b1);
    queue_word(64'h63_62_61_61, 4, 1'b1);
    queue_word(64'h62_61_78, 3, 1'b0);
    wait_idle();

    // shrink the length mid-text: held "ab" plus 'c' give a removal of 'a', then 'b', 'c'
    write_reg(prf_pkg::CFG_IDX_LEN, 64'd1);
    queue_word(64'h63, 1, 1'b1);
    wait_idle();

    // all-ones pattern, length field 15 acts as 8
    write_reg(prf_pkg::CFG_IDX_PATTERN, '1);
    write_reg(prf_pkg::CFG_IDX_LEN, {60'hA5A5_A5A5_A5A5_A5A, 4'hF});
    queue_word('1, 8, 1'b1);
    wait_idle();

    // random phases; some leave a text open across the next register write
    while (rand_chars < RANDOM_CHARS) begin
      new_random_setting();
      repeat ($urandom_range(1, 4)) queue_random_text(1'b1);
      if ($urandom_range(0, 4) == 0) queue_random_text(1'b0);
      wait_idle();
    end
    queue_word(64'h00, 1, 1'b1);
    wait_idle();

    $display("Run covered %0d characters (%0d random) in %0d closed texts, %0d results checked.",
             chars_taken, rand_chars, texts_closed, results_seen);
    $display("%0d pattern removals, %0d register writes, oversized and mid-text lengths included.",
             removals_total, reg_writes);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("pattern_removal_stream_filter verification clean");
    end else begin
      $display("pattern_removal_stream_filter verification failed");
    end
    $finish;
  end

endmodule
